### hw/rtl/sem_pkg.sv
// Shared types, codes and arithmetic helpers for the Sobel edge magnitude block.
// Used by every module of the block but sem_ram; depends on nothing.
package sem_pkg;

    // Width of the configuration data
    localparam int CFG_W = 11;

    // Configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Input operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Root steps for a 16-bit radicand, and the saturation limit of the sum
    localparam int          SQRT_STEPS = 8;
    localparam logic [20:0] SUM_LIMIT  = 21'd65280;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Packed RGB pixel: red [23:16], green [15:8], blue [7:0]
    typedef logic [23:0] pix_t;

    // One window column, top to bottom
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    // One result to compute: three columns plus the flags of the result
    typedef struct packed {
        col_t left;
        col_t centre;
        col_t right;
        logic eof;
        logic last;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_JOB_A,
        F_JOB_B
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GRAD,
        B_SQUARE,
        B_ROOT,
        B_FIN
    } back_state_t;

    typedef struct packed {
        logic [7:0] root;
        logic [8:0] rem;
    } sqrt_t;

    // Absolute value of (p0 + 2*p1 + p2) - (m0 + 2*m1 + m2)
    function automatic logic [9:0] weighted_diff(
        input logic [7:0] p0,
        input logic [7:0] p1,
        input logic [7:0] p2,
        input logic [7:0] m0,
        input logic [7:0] m1,
        input logic [7:0] m2
    );
        logic [9:0] ps;
        logic [9:0] ms;
        ps = 10'(p0) + {1'b0, p1, 1'b0} + 10'(p2);
        ms = 10'(m0) + {1'b0, m1, 1'b0} + 10'(m2);
        return (ps >= ms) ? (ps - ms) : (ms - ps);
    endfunction

    // One digit of the restoring square root: bring down two radicand bits
    function automatic sqrt_t sqrt_step(
        input logic [7:0] root,
        input logic [8:0] rem,
        input logic [1:0] pair
    );
        logic [10:0] cur;
        logic [10:0] trial;
        sqrt_t       res;
        cur   = {rem, pair};
        trial = {1'b0, root, 2'b01};
        if (cur >= trial)
        begin
            res.rem  = 9'(cur - trial);
            res.root = {root[6:0], 1'b1};
        end
        else
        begin
            res.rem  = cur[8:0];
            res.root = {root[6:0], 1'b0};
        end
        return res;
    endfunction

endpackage

### hw/rtl/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module sem_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/sem_front.sv
// Front end: takes items, keeps the line stores, counters and window, and
// queues up to two result jobs per item. Depends on sem_pkg and sem_ram.
module sem_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       operation,
    input  logic [7:0]                 red_in,
    input  logic [7:0]                 green_in,
    input  logic [7:0]                 blue_in,
    output logic                       push,
    output sem_pkg::job_t              push_job,
    input  logic                       full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    sem_pkg::front_state_t state_reg, state_next;

    logic [sem_pkg::CFG_W-1:0] width_reg;
    logic [sem_pkg::CFG_W-1:0] height_reg;
    logic [CW-1:0]             colcnt_reg;
    logic [RW-1:0]             rowcnt_reg;
    logic                      flush_reg;
    sem_pkg::pix_t             pix_reg;
    sem_pkg::col_t             cur_col_reg;
    sem_pkg::col_t             win_left_reg;
    sem_pkg::col_t             win_centre_reg;

    logic [CW-1:0] width_m1;
    logic [RW-1:0] height_eff;
    logic          col_last;
    logic          job_a;
    logic          job_b;
    logic          take;
    logic          cfg_wr;
    logic          ram_rd_en;
    logic          ram_wr_en;
    logic          finish;
    logic [47:0]   ram_rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    // Clamp the frame size registers to the supported range
    always_comb
    begin
        if (width_reg == '0)
            width_m1 = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            width_m1 = CW'(MAX_WIDTH - 1);
        else
            width_m1 = CW'(width_reg) - CW'(1);

        if (height_reg == '0)
            height_eff = RW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            height_eff = RW'(MAX_HEIGHT);
        else
            height_eff = RW'(height_reg);
    end

    assign col_last = (colcnt_reg == width_m1);
    assign job_a    = (rowcnt_reg != '0) && (colcnt_reg != '0);
    assign job_b    = (rowcnt_reg != '0) && col_last;

    // A flush item before the end of the last row is dropped
    assign take = in_valid && !((operation == sem_pkg::OP_FLUSH) && !flush_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sem_pkg::F_IDLE:  if (take) state_next = sem_pkg::F_READ;
            sem_pkg::F_READ:  state_next = sem_pkg::F_JOB_A;
            sem_pkg::F_JOB_A: if (!job_a || !full) state_next = sem_pkg::F_JOB_B;
            sem_pkg::F_JOB_B: if (!job_b || !full) state_next = sem_pkg::F_IDLE;
            default:          state_next = sem_pkg::F_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall  = 1'b1;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        push      = 1'b0;
        finish    = 1'b0;
        unique case (state_reg)
            sem_pkg::F_IDLE:
            begin
                in_stall  = 1'b0;
                ram_rd_en = in_valid;
            end
            sem_pkg::F_READ:
            begin
                ram_wr_en = !flush_reg;
            end
            sem_pkg::F_JOB_A:
            begin
                push = job_a && !full;
            end
            sem_pkg::F_JOB_B:
            begin
                push   = job_b && !full;
                finish = !job_b || !full;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Pick the job for the current slot
    always_comb
    begin
        if (state_reg == sem_pkg::F_JOB_B)
        begin
            push_job.left   = (colcnt_reg == '0) ? '0 : win_centre_reg;
            push_job.centre = cur_col_reg;
            push_job.right  = '0;
            push_job.eof    = flush_reg;
            push_job.last   = 1'b1;
        end
        else
        begin
            push_job.left   = win_left_reg;
            push_job.centre = win_centre_reg;
            push_job.right  = cur_col_reg;
            push_job.eof    = 1'b0;
            push_job.last   = !col_last;
        end
    end

    // Line stores: upper row in the high half, middle row in the low half
    sem_ram #(
        .WIDTH (48),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (colcnt_reg),
        .wr_data ({ram_rd_data[23:0], pix_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (colcnt_reg),
        .rd_data (ram_rd_data)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sem_pkg::F_IDLE;
            width_reg      <= sem_pkg::CFG_W'(640);
            height_reg     <= sem_pkg::CFG_W'(480);
            colcnt_reg     <= '0;
            rowcnt_reg     <= '0;
            flush_reg      <= 1'b0;
            win_left_reg   <= '0;
            win_centre_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                // Any write restarts the frame
                unique case (cfg_index)
                    sem_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    sem_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:                   width_reg  <= width_reg;
                endcase
                colcnt_reg     <= '0;
                rowcnt_reg     <= '0;
                flush_reg      <= 1'b0;
                win_left_reg   <= '0;
                win_centre_reg <= '0;
            end
            else if (finish)
            begin
                // Advance the window and the raster position
                win_left_reg   <= (colcnt_reg == '0) ? '0 : win_centre_reg;
                win_centre_reg <= cur_col_reg;
                if (col_last)
                begin
                    colcnt_reg <= '0;
                    if (flush_reg)
                    begin
                        rowcnt_reg <= '0;
                        flush_reg  <= 1'b0;
                    end
                    else
                    begin
                        rowcnt_reg <= rowcnt_reg + RW'(1);
                        if ((rowcnt_reg + RW'(1)) >= height_eff)
                            flush_reg <= 1'b1;
                    end
                end
                else
                begin
                    colcnt_reg <= colcnt_reg + CW'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == sem_pkg::F_IDLE && take)
        begin
            pix_reg <= flush_reg ? '0 : {red_in, green_in, blue_in};
        end
        if (state_reg == sem_pkg::F_READ)
        begin
            cur_col_reg.top <= (32'(rowcnt_reg) >= 32'd2) ? ram_rd_data[47:24] : '0;
            cur_col_reg.mid <= (rowcnt_reg != '0) ? ram_rd_data[23:0] : '0;
            cur_col_reg.bot <= pix_reg;
        end
    end

endmodule

### hw/rtl/sem_queue.sv
// Two-entry job queue between the front and back ends.
// Depends on sem_pkg for the job type.
module sem_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sem_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output sem_pkg::job_t pop_job,
    output logic          empty
);

    localparam int PW = $clog2(sem_pkg::QUEUE_DEPTH);

    sem_pkg::job_t entry_reg [sem_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full    = (count_reg == (PW + 1)'(sem_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + (PW + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PW + 1)'(1);
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### hw/rtl/sem_back.sv
// Back end: gradients, squared sum and rounded square root per channel,
// with an output register. Depends on sem_pkg.
module sem_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    output logic          pop,
    input  sem_pkg::job_t pop_job,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    red_edge,
    output logic [7:0]    green_edge,
    output logic [7:0]    blue_edge,
    output logic          end_of_frame,
    output logic          last_of_run
);

    sem_pkg::back_state_t state_reg, state_next;

    sem_pkg::job_t job_reg;
    logic [9:0]    gx_reg   [3];
    logic [9:0]    gy_reg   [3];
    logic          sat_reg  [3];
    logic [15:0]   s_reg    [3];
    logic [7:0]    root_reg [3];
    logic [8:0]    rem_reg  [3];
    logic [2:0]    step_reg;
    logic [7:0]    edge_reg [3];
    logic          eof_reg;
    logic          last_reg;
    logic          out_valid_reg;

    logic [19:0]   sqx      [3];
    logic [19:0]   sqy      [3];
    logic [20:0]   sum      [3];
    sem_pkg::sqrt_t step_res [3];
    logic          out_free;
    logic          load_out;
    logic          step_done;

    assign out_free  = !out_valid_reg || !out_stall;
    assign step_done = (step_reg == 3'(sem_pkg::SQRT_STEPS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sem_pkg::B_IDLE:   if (!empty) state_next = sem_pkg::B_GRAD;
            sem_pkg::B_GRAD:   state_next = sem_pkg::B_SQUARE;
            sem_pkg::B_SQUARE: state_next = sem_pkg::B_ROOT;
            sem_pkg::B_ROOT:   if (step_done) state_next = sem_pkg::B_FIN;
            sem_pkg::B_FIN:    if (out_free) state_next = sem_pkg::B_IDLE;
            default:           state_next = sem_pkg::B_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            sem_pkg::B_IDLE: pop      = !empty;
            sem_pkg::B_FIN:  load_out = out_free;
            default:         pop      = 1'b0;
        endcase
    end

    // Squares and root step per channel
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sqx[ch]      = 20'(gx_reg[ch]) * 20'(gx_reg[ch]);
            sqy[ch]      = 20'(gy_reg[ch]) * 20'(gy_reg[ch]);
            sum[ch]      = 21'(sqx[ch]) + 21'(sqy[ch]);
            step_res[ch] = sem_pkg::sqrt_step(root_reg[ch], rem_reg[ch], s_reg[ch][15:14]);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sem_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == sem_pkg::B_SQUARE)
                step_reg <= '0;
            else if (state_reg == sem_pkg::B_ROOT)
                step_reg <= step_reg + 3'(1);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= pop_job;
        for (int ch = 0; ch < 3; ch++)
        begin
            // Sobel Gx from the side columns, Gy from the top and bottom rows
            if (state_reg == sem_pkg::B_GRAD)
            begin
                gx_reg[ch] <= sem_pkg::weighted_diff(
                    job_reg.right.top[8*(2-ch) +: 8], job_reg.right.mid[8*(2-ch) +: 8],
                    job_reg.right.bot[8*(2-ch) +: 8], job_reg.left.top[8*(2-ch) +: 8],
                    job_reg.left.mid[8*(2-ch) +: 8], job_reg.left.bot[8*(2-ch) +: 8]);
                gy_reg[ch] <= sem_pkg::weighted_diff(
                    job_reg.left.bot[8*(2-ch) +: 8], job_reg.centre.bot[8*(2-ch) +: 8],
                    job_reg.right.bot[8*(2-ch) +: 8], job_reg.left.top[8*(2-ch) +: 8],
                    job_reg.centre.top[8*(2-ch) +: 8], job_reg.right.top[8*(2-ch) +: 8]);
            end
            if (state_reg == sem_pkg::B_SQUARE)
            begin
                sat_reg[ch]  <= (sum[ch] > sem_pkg::SUM_LIMIT);
                s_reg[ch]    <= sum[ch][15:0];
                root_reg[ch] <= '0;
                rem_reg[ch]  <= '0;
            end
            if (state_reg == sem_pkg::B_ROOT)
            begin
                root_reg[ch] <= step_res[ch].root;
                rem_reg[ch]  <= step_res[ch].rem;
                s_reg[ch]    <= {s_reg[ch][13:0], 2'b00};
            end
            // Round to nearest: bump the root when the remainder exceeds it
            if (load_out)
            begin
                if (sat_reg[ch])
                    edge_reg[ch] <= 8'hFF;
                else if (rem_reg[ch] > {1'b0, root_reg[ch]})
                    edge_reg[ch] <= root_reg[ch] + 8'd1;
                else
                    edge_reg[ch] <= root_reg[ch];
            end
        end
        if (load_out)
        begin
            eof_reg  <= job_reg.eof;
            last_reg <= job_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_edge     = edge_reg[0];
    assign green_edge   = edge_reg[1];
    assign blue_edge    = edge_reg[2];
    assign end_of_frame = eof_reg;
    assign last_of_run  = last_reg;

endmodule

### hw/rtl/sobel_edge_magnitude_rgb_core.sv
// Top level of the RGB Sobel edge magnitude block.
// Depends on sem_pkg, sem_front, sem_queue, sem_back and sem_ram.
//
// Streaming 3x3 Sobel gradient magnitude per colour channel over RGB pixels
// in raster order, with neighbours outside the frame taken as zero. The
// result for row r, column c leaves when item (r+1, c+1) arrives; the last
// column of a row yields two results, and after the last row the sender
// supplies frame_width flush items. For each item the front end steps
// through accept, line store read (for the registered read of the combined
// line store) and two job slots, and takes no new item until the job slots
// are done. Each result then passes through the back end's fetch, gradient,
// square, eight root steps and finish, and the back end takes no new job
// until it is done; a two-entry queue lets either end stall on its own.
// Writing a frame size register restarts the frame.
module sobel_edge_magnitude_rgb_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [sem_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      operation,
    input  logic [7:0]                red_in,
    input  logic [7:0]                green_in,
    input  logic [7:0]                blue_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                red_edge,
    output logic [7:0]                green_edge,
    output logic [7:0]                blue_edge,
    output logic                      end_of_frame,
    output logic                      last_of_run
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    sem_pkg::job_t push_job;
    sem_pkg::job_t pop_job;

    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .push      (push),
        .push_job  (push_job),
        .full      (full)
    );

    sem_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    sem_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop          (pop),
        .pop_job      (pop_job),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_edge     (red_edge),
        .green_edge   (green_edge),
        .blue_edge    (blue_edge),
        .end_of_frame (end_of_frame),
        .last_of_run  (last_of_run)
    );

endmodule

### hw/rtl/sem_checker.sv
// Port-level checks for the Sobel edge magnitude block, bound to the top level.
// Depends on sem_pkg for codes and widths.
module sem_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic                      cfg_index,
    input logic [sem_pkg::CFG_W-1:0] cfg_data,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      operation,
    input logic [7:0]                red_in,
    input logic [7:0]                green_in,
    input logic [7:0]                blue_in,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [7:0]                red_edge,
    input logic [7:0]                green_edge,
    input logic [7:0]                blue_edge,
    input logic                      end_of_frame,
    input logic                      last_of_run
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable({red_edge, green_edge, blue_edge, end_of_frame, last_of_run}))
        else $error("stalled result changed");

    // The frame's last result closes its run
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> last_of_run)
        else $error("end of frame on a result that is not last of run");

    // A taken pixel keeps the front busy for its line store access
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (operation == sem_pkg::OP_PIXEL) |=> in_stall)
        else $error("front took a second item during a line store access");

endmodule

bind sobel_edge_magnitude_rgb_core sem_checker u_sem_checker (.*);
